// ===== src/rect_fill_and_copy_l8_writer_macros.svh =====
// Assertion macros used by the rectangle writer engine RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef RECT_FILL_AND_COPY_L8_WRITER_MACROS_SVH
`define RECT_FILL_AND_COPY_L8_WRITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFCW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFCW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rfcw_pkg.sv =====
package rfcw_pkg;

	localparam int DIM_W = 12;
	localparam int OFS_W = 19;
	localparam int IDX_W = 8;
	localparam int ARGB_W = 32;

	// RGB332 field masks after aligning each color channel
	localparam logic [ARGB_W-1:0] RED_MASK = 32'h0000_00E0;
	localparam logic [ARGB_W-1:0] GRN_MASK = 32'h0000_001C;
	localparam logic [ARGB_W-1:0] BLU_MASK = 32'h0000_0003;

	typedef enum logic [1:0] {
		OP_FILL_START = 2'd0,
		OP_COPY_START = 2'd1,
		OP_PIXEL      = 2'd2,
		OP_TICK       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_NO_OP  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_FILL = 2'd1,
		MODE_COPY = 2'd2
	} mode_t;

	typedef struct packed {
		op_t               op;
		logic [DIM_W-1:0]  x;
		logic [DIM_W-1:0]  y;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [ARGB_W-1:0] color;
	} req_item_t;

	typedef struct packed {
		logic              write_valid;
		logic [OFS_W-1:0]  write_offset;
		logic [IDX_W-1:0]  write_index;
		status_t           status;
		logic              last;
	} rsp_item_t;

	// ARGB8888 to RGB332: top 3/3/2 bits of red/green/blue
	function automatic logic [IDX_W-1:0] quantise(input logic [ARGB_W-1:0] c);
		logic [ARGB_W-1:0] q;
		q = ((c >> 16) & RED_MASK) | ((c >> 11) & GRN_MASK) | ((c >> 6) & BLU_MASK);
		return q[IDX_W-1:0];
	endfunction

endpackage

// ===== src/rfcw_if.sv =====
interface rfcw_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/rfcw_engine.sv =====
`include "rect_fill_and_copy_l8_writer_macros.svh"

module rfcw_engine #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 800
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  rfcw_pkg::req_item_t item,
	output rfcw_pkg::rsp_item_t result
);
	import rfcw_pkg::*;

	localparam logic [DIM_W-1:0] SW_D = DIM_W'(SCREEN_WIDTH);
	localparam logic [DIM_W-1:0] SH_D = DIM_W'(SCREEN_HEIGHT);
	localparam logic [OFS_W-1:0] SW_O = OFS_W'(SCREEN_WIDTH);

	mode_t            mode_q, mode_n;
	logic [IDX_W-1:0] fill_index_q, fill_index_n;
	logic [DIM_W-1:0] left_column_q, left_column_n;
	logic [DIM_W-1:0] span_w_q, span_w_n;
	logic [DIM_W-1:0] span_h_q, span_h_n;
	logic [DIM_W-1:0] col_q, col_n;
	logic [DIM_W-1:0] row_q, row_n;
	logic [OFS_W-1:0] row_base_q, row_base_n;

	logic [DIM_W:0]     x_end, y_end;
	logic               x_over, y_over;
	logic [DIM_W-1:0]   w_eff, h_eff;
	logic               reject;
	logic [2*DIM_W-1:0] origin_prod;
	logic [OFS_W-1:0]   origin_ofs;
	logic [DIM_W-1:0]   col_inc, row_inc;
	logic               row_done, rect_done;
	logic [IDX_W-1:0]   emit_index;
	logic               emit_ok;

	assign x_end  = {1'b0, item.x} + {1'b0, item.width};
	assign y_end  = {1'b0, item.y} + {1'b0, item.height};
	assign x_over = x_end > {1'b0, SW_D};
	assign y_over = y_end > {1'b0, SH_D};

	assign origin_prod = {{DIM_W{1'b0}}, item.y} * {{DIM_W{1'b0}}, SW_D};
	assign origin_ofs  = origin_prod[OFS_W-1:0] + {{(OFS_W-DIM_W){1'b0}}, item.x};

	assign col_inc   = col_q + 1'b1;
	assign row_inc   = row_q + 1'b1;
	assign row_done  = col_inc >= span_w_q;
	assign rect_done = row_done && (row_inc >= span_h_q);

	always_comb begin
		w_eff  = item.width;
		h_eff  = item.height;
		reject = 1'b0;
		if (item.op == OP_FILL_START) begin
			reject = (item.x >= SW_D) || (item.y >= SH_D);
			if (x_over) begin
				w_eff = SW_D - item.x;
			end
			if (y_over) begin
				h_eff = SH_D - item.y;
			end
		end else begin
			reject = x_over || y_over;
		end
	end

	assign emit_index = (item.op == OP_PIXEL) ? quantise(item.color) : fill_index_q;
	assign emit_ok    = (item.op == OP_PIXEL) ? (mode_q == MODE_COPY) : (mode_q == MODE_FILL);

	always_comb begin
		mode_n        = mode_q;
		fill_index_n  = fill_index_q;
		left_column_n = left_column_q;
		span_w_n      = span_w_q;
		span_h_n      = span_h_q;
		col_n         = col_q;
		row_n         = row_q;
		row_base_n    = row_base_q;
		result        = '0;
		result.status = ST_OK;
		unique case (item.op)
			OP_FILL_START, OP_COPY_START: begin
				mode_n = MODE_IDLE;
				if (reject) begin
					result.status = ST_REJECT;
				end else begin
					if (item.op == OP_FILL_START) begin
						fill_index_n = quantise(item.color);
					end
					if (w_eff == '0 || h_eff == '0) begin
						result.last = 1'b1;
					end else begin
						left_column_n = item.x;
						span_w_n      = w_eff;
						span_h_n      = h_eff;
						col_n         = '0;
						row_n         = '0;
						row_base_n    = origin_ofs;
						mode_n        = (item.op == OP_FILL_START) ? MODE_FILL : MODE_COPY;
					end
				end
			end
			OP_PIXEL, OP_TICK: begin
				if (!emit_ok) begin
					result.status = ST_NO_OP;
				end else begin
					result.write_valid  = 1'b1;
					result.write_offset = row_base_q + {{(OFS_W-DIM_W){1'b0}}, col_q};
					result.write_index  = emit_index;
					col_n = col_inc;
					if (row_done) begin
						col_n      = '0;
						row_n      = row_inc;
						row_base_n = row_base_q + SW_O;
						if (rect_done) begin
							result.last = 1'b1;
							mode_n      = MODE_IDLE;
						end
					end
				end
			end
			default: begin
				result.status = ST_NO_OP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			fill_index_q  <= '0;
			left_column_q <= '0;
			span_w_q      <= '0;
			span_h_q      <= '0;
			col_q         <= '0;
			row_q         <= '0;
			row_base_q    <= '0;
		end else if (step) begin
			mode_q        <= mode_n;
			fill_index_q  <= fill_index_n;
			left_column_q <= left_column_n;
			span_w_q      <= span_w_n;
			span_h_q      <= span_h_n;
			col_q         <= col_n;
			row_q         <= row_n;
			row_base_q    <= row_base_n;
		end
	end

	`RFCW_ASSERT_IMP(a_span_nonzero, mode_q != MODE_IDLE, span_w_q != '0 && span_h_q != '0, "active rectangle with empty span")
	`RFCW_ASSERT_IMP(a_pos_in_span, mode_q != MODE_IDLE, col_q < span_w_q && row_q < span_h_q, "write position outside span")
	`RFCW_ASSERT_NXT(a_last_idles, step && result.write_valid && result.last, mode_q == MODE_IDLE, "final write left block active")
	`RFCW_ASSERT_NXT(a_noop_holds, step && result.status == ST_NO_OP, $stable(mode_q) && $stable(row_base_q) && $stable(col_q), "unmatched item changed state")

endmodule

// ===== src/rect_fill_and_copy_l8_writer.sv =====
// Rectangle fill and copy writer for an RGB332 byte-per-pixel frame buffer.
//
// Channels: req carries operation items (fill start, copy start, pixel data,
// fill tick) with origin, size and ARGB8888 color; rsp carries exactly one
// result per request: an optional frame buffer byte write (offset, RGB332
// index), a status code and a last flag. A transfer happens on a rising clk
// edge with valid and ready both high.
//
// Structure: an input register holds one accepted item; the walker logic
// evaluates it against the rectangle state and loads the result register,
// updating the state in the same edge. Offsets need one 12x12 multiply
// (origin row times screen width) plus an add on the start path.
//
// Path: a request passes the input register, then the result register, before rsp.
// Throughput: one item per cycle while rsp is ready: one byte write per fill tick.
// When rsp stalls, the result register holds, the input register keeps one
// more item, and req.ready drops only when both are full.
//
// Reset (arst_n low): both stages empty, no rectangle active, all counters
// cleared. The block is ready as soon as reset is released.
module rect_fill_and_copy_l8_writer #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 800
) (
	input  logic         clk,
	input  logic         arst_n,
	rfcw_if.sink         req,
	rfcw_if.source       rsp
);
	import rfcw_pkg::*;

	logic      s1_valid_q;
	req_item_t item_s1;
	logic      s2_valid_q;
	rsp_item_t result_s2;
	rsp_item_t result;
	logic      advance;
	logic      req_xfer;

	// Move the held item into the result stage when that stage is free or drains.
	assign advance  = s1_valid_q && (!s2_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || advance;
	assign req_xfer = req.valid && req.ready;

	// Input stage: hold one accepted item until the walker consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			item_s1 <= req.data;
		end
	end

	// Walker: state advances only when its result is captured.
	rfcw_engine #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// Result stage: hold while the receiver stalls, drop after the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (advance) begin
			s2_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid = s2_valid_q;
	assign rsp.data  = result_s2;

endmodule
